[src/arsp_pkg.sv]
`default_nettype none

package arsp_pkg;

   // Timing base of the duration conversion
   localparam int TICK_US      = 10;
   localparam int TICKS_PER_MS = 100;

   localparam int TICK_W  = 10;   // holds TICK_US up to 1000
   localparam int TPM_W   = 10;   // holds TICKS_PER_MS up to 1000
   localparam int MS_W    = 32;
   localparam int US_W    = 16;
   localparam int DIV_W   = 17;   // rounded microseconds, us + TICK_US/2
   localparam int QUO_SHIFT = DIV_W;
   localparam int RECIP_W = QUO_SHIFT + 1;
   localparam int RECIP   = (1 << QUO_SHIFT) / TICK_US;
   localparam int HALF_TICK = TICK_US / 2;
   localparam int MSP_W   = MS_W + TPM_W;
   localparam int SUM_W   = MSP_W + 1;
   localparam int TICKS_W = 32;
   localparam logic [TICKS_W-1:0] TICKS_MAX = 32'hFFFF_FFFF;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // Input item codes
   localparam logic REQ_BYTE = 1'b0;
   localparam logic REQ_END  = 1'b1;

   // Result kinds
   localparam logic [1:0] KIND_RECORD = 2'd0;
   localparam logic [1:0] KIND_TARGET = 2'd1;
   localparam logic [1:0] KIND_END    = 2'd2;

   // Record types
   localparam logic [2:0] REC_NONE        = 3'd0;
   localparam logic [2:0] REC_START       = 3'd1;
   localparam logic [2:0] REC_DELAY       = 3'd2;
   localparam logic [2:0] REC_PIN_READ    = 3'd3;
   localparam logic [2:0] REC_PIN_WRITE   = 3'd4;
   localparam logic [2:0] REC_PIN_TRIGGER = 3'd5;

   // End status codes
   localparam logic [2:0] ST_OK            = 3'd0;
   localparam logic [2:0] ST_SHORT_HEADER  = 3'd1;
   localparam logic [2:0] ST_SHORT_FIELDS  = 3'd2;
   localparam logic [2:0] ST_SHORT_TARGETS = 3'd3;
   localparam logic [2:0] ST_BAD_TYPE      = 3'd4;

   // Classified item passed from the front to the back
   typedef struct packed {
      logic [1:0]       kind;
      logic [2:0]       action_type;
      logic [7:0]       action_id;
      logic [7:0]       port;
      logic [7:0]       pin;
      logic [7:0]       initial_level;
      logic [7:0]       target_level;
      logic [7:0]       final_level;
      logic             has_duration;
      logic [MS_W-1:0]  millis;
      logic [US_W-1:0]  micros;
      logic [8:0]       count;
      logic [7:0]       target_id;
      logic [2:0]       status;
   } op_type;

endpackage

`default_nettype wire

[src/arsp_req_if.sv]
`default_nettype none

interface arsp_req_if;
   logic       valid;
   logic       ready;
   logic       req_type;
   logic [7:0] data_byte;

   modport source (output valid, output req_type, output data_byte, input ready);
   modport sink   (input valid, input req_type, input data_byte, output ready);
endinterface

`default_nettype wire

[src/arsp_rsp_if.sv]
`default_nettype none

interface arsp_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [2:0]  action_type;
   logic [7:0]  action_id;
   logic [7:0]  port;
   logic [7:0]  pin;
   logic [7:0]  initial_level;
   logic [7:0]  target_level;
   logic [7:0]  final_level;
   logic [31:0] interval_ticks;
   logic [8:0]  count;
   logic [7:0]  target_id;
   logic [2:0]  status;

   modport source (output valid, output kind, output action_type, output action_id,
                   output port, output pin, output initial_level, output target_level,
                   output final_level, output interval_ticks, output count,
                   output target_id, output status, input ready);
   modport sink   (input valid, input kind, input action_type, input action_id,
                   input port, input pin, input initial_level, input target_level,
                   input final_level, input interval_ticks, input count,
                   input target_id, input status, output ready);
endinterface

`default_nettype wire

[src/arsp_front.sv]
`default_nettype none

module arsp_front (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   input  logic            in_req_type,
   input  logic [7:0]      in_data_byte,
   input  logic            queue_full,
   output logic            accept,
   output logic            push,
   output arsp_pkg::op_type push_op
);
   import arsp_pkg::*;

   typedef enum logic [2:0] {
      PH_TYPE, PH_ID, PH_FIELDS, PH_TARGETS, PH_SKIP
   } phase_type;

   phase_type        phase_ff, phase_in;
   logic [2:0]       type_ff, type_in;
   logic             bad_ff, bad_in;
   logic [7:0]       id_ff, id_in;
   logic [3:0]       pos_ff, pos_in;
   logic [7:0]       pins_ff [5];
   logic [7:0]       pins_in [5];
   logic [MS_W-1:0]  ms_ff, ms_in;
   logic [US_W-1:0]  us_ff, us_in;
   logic [7:0]       left_ff, left_in;
   logic [8:0]       largest_ff, largest_in;
   logic [3:0]       pin_len;
   logic [3:0]       fixed_len;
   logic             pin_rec;

   always_comb begin
      unique case (type_ff)
         REC_PIN_READ, REC_PIN_WRITE: begin
            pin_len   = 4'd5;
            fixed_len = 4'd11;
         end
         REC_PIN_TRIGGER: begin
            pin_len   = 4'd4;
            fixed_len = 4'd10;
         end
         REC_DELAY: begin
            pin_len   = 4'd0;
            fixed_len = 4'd6;
         end
         default: begin
            pin_len   = 4'd0;
            fixed_len = 4'd0;
         end
      endcase
   end

   assign pin_rec = (pin_len != 4'd0);
   assign accept  = in_valid && !queue_full;

   always_comb begin
      phase_in   = phase_ff;
      type_in    = type_ff;
      bad_in     = bad_ff;
      id_in      = id_ff;
      pos_in     = pos_ff;
      pins_in    = pins_ff;
      ms_in      = ms_ff;
      us_in      = us_ff;
      left_in    = left_ff;
      largest_in = largest_ff;
      push       = 1'b0;
      push_op    = '0;

      if (accept) begin
         if (in_req_type == REQ_END) begin
            push         = 1'b1;
            push_op.kind = KIND_END;
            unique case (phase_ff)
               PH_SKIP:    push_op.status = ST_BAD_TYPE;
               PH_ID:      push_op.status = ST_SHORT_HEADER;
               PH_FIELDS:  push_op.status = ST_SHORT_FIELDS;
               PH_TARGETS: push_op.status = ST_SHORT_TARGETS;
               default:    push_op.status = ST_OK;
            endcase
            if (push_op.status == ST_OK && !largest_ff[8]) begin
               push_op.count = {1'b0, largest_ff[7:0]} + 9'd1;
            end
            phase_in   = PH_TYPE;
            largest_in = 9'h100;
         end else begin
            unique case (phase_ff)
               PH_TYPE: begin
                  type_in  = in_data_byte[2:0];
                  bad_in   = (in_data_byte == 8'd0) || (in_data_byte > 8'd5);
                  phase_in = PH_ID;
               end
               PH_ID: begin
                  id_in = in_data_byte;
                  if (largest_ff[8] || in_data_byte > largest_ff[7:0]) begin
                     largest_in = {1'b0, in_data_byte};
                  end
                  if (bad_ff) begin
                     phase_in = PH_SKIP;
                  end else begin
                     pos_in   = 4'd0;
                     for (int i = 0; i < 5; i++) pins_in[i] = 8'd0;
                     ms_in    = '0;
                     us_in    = '0;
                     phase_in = PH_FIELDS;
                  end
               end
               PH_FIELDS: begin
                  if (pos_ff < fixed_len) begin
                     if (pos_ff < pin_len) begin
                        pins_in[pos_ff[2:0]] = in_data_byte;
                     end else if (pos_ff < pin_len + 4'd4) begin
                        ms_in = {ms_ff[MS_W-9:0], in_data_byte};
                     end else begin
                        us_in = {us_ff[US_W-9:0], in_data_byte};
                     end
                     pos_in = pos_ff + 4'd1;
                  end else begin
                     push                 = 1'b1;
                     push_op.kind         = KIND_RECORD;
                     push_op.action_type  = type_ff;
                     push_op.action_id    = id_ff;
                     if (pin_rec) begin
                        push_op.port          = pins_ff[0];
                        push_op.pin           = pins_ff[1];
                        push_op.initial_level = pins_ff[2];
                        push_op.target_level  = pins_ff[3];
                        push_op.final_level   =
                           (type_ff == REC_PIN_TRIGGER) ? 8'd0 : pins_ff[4];
                     end
                     push_op.has_duration = (type_ff != REC_START);
                     push_op.millis       = ms_ff;
                     push_op.micros       = us_ff;
                     push_op.count        = {1'b0, in_data_byte};
                     left_in  = in_data_byte;
                     phase_in = (in_data_byte != 8'd0) ? PH_TARGETS : PH_TYPE;
                  end
               end
               PH_TARGETS: begin
                  push                = 1'b1;
                  push_op.kind        = KIND_TARGET;
                  push_op.action_type = type_ff;
                  push_op.action_id   = id_ff;
                  push_op.target_id   = in_data_byte;
                  left_in = left_ff - 8'd1;
                  if (left_ff == 8'd1) phase_in = PH_TYPE;
               end
               default: begin
                  phase_in = phase_ff;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_TYPE;
         largest_ff <= 9'h100;
         bad_ff     <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         largest_ff <= largest_in;
         bad_ff     <= bad_in;
      end
      type_ff <= type_in;
      id_ff   <= id_in;
      pos_ff  <= pos_in;
      pins_ff <= pins_in;
      ms_ff   <= ms_in;
      us_ff   <= us_in;
      left_ff <= left_in;
   end

endmodule

`default_nettype wire

[src/arsp_queue.sv]
`default_nettype none

module arsp_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  arsp_pkg::op_type push_op,
   output logic             full,
   input  logic             pop,
   output logic             nonempty,
   output arsp_pkg::op_type head_op
);
   import arsp_pkg::*;

   op_type            slots_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ff, rd_ff;
   logic [QPTR_W:0]   used_ff;
   logic              do_pop;

   assign full     = (used_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign nonempty = (used_ff != '0);
   assign head_op  = slots_ff[rd_ff];
   assign do_pop   = pop && nonempty;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= '0;
         rd_ff   <= '0;
         used_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= (wr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ff <= (rd_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
         end
         used_ff <= used_ff + (QPTR_W+1)'(push) - (QPTR_W+1)'(do_pop);
      end
      if (push) slots_ff[wr_ff] <= push_op;
   end

endmodule

`default_nettype wire

[src/arsp_back.sv]
`default_nettype none

module arsp_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                head_valid,
   input  arsp_pkg::op_type    head_op,
   output logic                pop,
   input  logic                out_ready,
   output logic                out_valid,
   output arsp_pkg::op_type    out_op,
   output logic [31:0]         out_ticks
);
   import arsp_pkg::*;

   localparam logic [TICK_W-1:0]  TICK_C  = TICK_W'(TICK_US);
   localparam logic [TPM_W-1:0]   TPM_C   = TPM_W'(TICKS_PER_MS);
   localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP);
   localparam logic [DIV_W-1:0]   HALF_C  = DIV_W'(HALF_TICK);
   localparam int PROD_W = DIV_W + RECIP_W;
   localparam int QD_W   = DIV_W + TICK_W;

   typedef struct packed {
      op_type           op;
      logic [DIV_W-1:0] rounded;
      logic [DIV_W-1:0] quo_est;
      logic [MSP_W-1:0] ms_ticks;
   } s1_type;

   typedef struct packed {
      op_type           op;
      logic [DIV_W-1:0] rounded;
      logic [DIV_W-1:0] quo_est;
      logic [DIV_W-1:0] quo_back;
      logic [MSP_W-1:0] ms_ticks;
   } s2_type;

   logic              adv;
   logic              s1_valid_ff, s2_valid_ff, out_valid_ff;
   s1_type            s1_ff, s1_in;
   s2_type            s2_ff, s2_in;
   op_type            out_op_ff;
   logic [TICKS_W-1:0] ticks_ff, ticks_in;
   logic [PROD_W-1:0] recip_prod;
   logic [QD_W-1:0]   qd_prod;
   logic [DIV_W-1:0]  rem;
   logic [DIV_W-1:0]  quo;
   logic [SUM_W-1:0]  sum;

   assign adv = !out_valid_ff || out_ready;
   assign pop = adv && head_valid;

   // Stage 1: reciprocal multiply of the rounded microseconds, scale milliseconds
   always_comb begin
      s1_in.op       = head_op;
      s1_in.rounded  = {1'b0, head_op.micros} + HALF_C;
      recip_prod     = PROD_W'(s1_in.rounded) * PROD_W'(RECIP_C);
      s1_in.quo_est  = recip_prod[QUO_SHIFT +: DIV_W];
      s1_in.ms_ticks = MSP_W'(head_op.millis) * MSP_W'(TPM_C);
   end

   // Stage 2: multiply the estimate back for the remainder check
   always_comb begin
      s2_in.op       = s1_ff.op;
      s2_in.rounded  = s1_ff.rounded;
      s2_in.quo_est  = s1_ff.quo_est;
      s2_in.ms_ticks = s1_ff.ms_ticks;
      qd_prod        = QD_W'(s1_ff.quo_est) * QD_W'(TICK_C);
      s2_in.quo_back = qd_prod[DIV_W-1:0];
   end

   // Stage 3: correct the estimate by one, add, saturate; zero without a duration
   always_comb begin
      rem = s2_ff.rounded - s2_ff.quo_back;
      quo = s2_ff.quo_est + DIV_W'(rem >= DIV_W'(TICK_C));
      sum = SUM_W'(s2_ff.ms_ticks) + SUM_W'(quo);
      if (!s2_ff.op.has_duration) begin
         ticks_in = '0;
      end else if (sum[SUM_W-1:TICKS_W] != '0) begin
         ticks_in = TICKS_MAX;
      end else begin
         ticks_in = sum[TICKS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff  <= head_valid;
         s2_valid_ff  <= s1_valid_ff;
         out_valid_ff <= s2_valid_ff;
      end
      if (adv) begin
         s1_ff     <= s1_in;
         s2_ff     <= s2_in;
         out_op_ff <= s2_ff.op;
         ticks_ff  <= ticks_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_op    = out_op_ff;
   assign out_ticks = ticks_ff;

endmodule

`default_nettype wire

[src/action_record_stream_parser.sv]
`default_nettype none

// Action record stream parser.
// The req_chan channel takes one item per handshake: a payload byte
// (req_type 0, data_byte) or an end-of-payload marker (req_type 1).
// The rsp_chan channel gives records, target ids and the end status of a
// payload. A record goes out when its count byte arrives, each following
// target byte as a target item, and the end marker gives the status with
// the action count, or the first error (count 0).
// Throughput: one item per cycle in each direction while neither side
// stalls. The front parses a byte in the cycle it is accepted and
// writes the result into a 4-entry queue; the back runs a three-stage
// pipeline (tick scaling multiply, remainder check multiply, correct
// and saturate) ending in the output register.
// Reset (synchronous, active high) drops everything queued or in flight
// and readies the parser for the start of a payload.
// When the receiver stalls, the output register and pipeline hold; the
// queue keeps taking items until it fills, then req_chan.ready drops.
module action_record_stream_parser (
   input  logic  clock,
   input  logic  reset,
   arsp_req_if.sink   req_chan,
   arsp_rsp_if.source rsp_chan
);
   import arsp_pkg::*;

   logic   accept;
   logic   push;
   op_type push_op;
   logic   queue_full;
   logic   head_valid;
   op_type head_op;
   logic   pop;
   logic   out_valid;
   op_type out_op;
   logic [31:0] out_ticks;

   // Front: parse bytes and classify them into queue entries
   arsp_front u_front (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_chan.valid),
      .in_req_type  (req_chan.req_type),
      .in_data_byte (req_chan.data_byte),
      .queue_full   (queue_full),
      .accept       (accept),
      .push         (push),
      .push_op      (push_op)
   );

   // Hold the input side off only when the queue is full
   assign req_chan.ready = !queue_full;

   arsp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push && accept),
      .push_op  (push_op),
      .full     (queue_full),
      .pop      (pop),
      .nonempty (head_valid),
      .head_op  (head_op)
   );

   // Back: convert durations and drive the output register
   arsp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_op    (head_op),
      .pop        (pop),
      .out_ready  (rsp_chan.ready),
      .out_valid  (out_valid),
      .out_op     (out_op),
      .out_ticks  (out_ticks)
   );

   assign rsp_chan.valid          = out_valid;
   assign rsp_chan.kind           = out_op.kind;
   assign rsp_chan.action_type    = out_op.action_type;
   assign rsp_chan.action_id      = out_op.action_id;
   assign rsp_chan.port           = out_op.port;
   assign rsp_chan.pin            = out_op.pin;
   assign rsp_chan.initial_level  = out_op.initial_level;
   assign rsp_chan.target_level   = out_op.target_level;
   assign rsp_chan.final_level    = out_op.final_level;
   assign rsp_chan.interval_ticks = out_ticks;
   assign rsp_chan.count          = out_op.count;
   assign rsp_chan.target_id      = out_op.target_id;
   assign rsp_chan.status         = out_op.status;

endmodule

`default_nettype wire

[verif/tb.sv]
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import arsp_pkg::*;

   // Give up after this many cycles without a handshake on either channel
   localparam int WATCHDOG_LIMIT = 2000;
   // Live payload items to send in the random part
   localparam int RANDOM_ITEMS   = 650;
   // Cycles to linger after the last result
   localparam int DRAIN_CYCLES   = 8;

   // One result item, in the order of the result channel's fields
   typedef struct packed {
      logic [1:0]  kind;
      logic [2:0]  action_type;
      logic [7:0]  action_id;
      logic [7:0]  port;
      logic [7:0]  pin;
      logic [7:0]  initial_level;
      logic [7:0]  target_level;
      logic [7:0]  final_level;
      logic [31:0] interval_ticks;
      logic [8:0]  count;
      logic [7:0]  target_id;
      logic [2:0]  status;
   } result_type;

   // One row of stimulus; a pinned row carries its result typed in by hand
   typedef struct {
      logic       rtype;
      logic [7:0] data;
      bit         pinned;
      result_type want;
   } stim_row_type;

   // Where the decoder stands within a payload
   typedef enum logic [2:0] {
      AWAIT_TYPE,
      AWAIT_ID,
      IN_FIELDS,
      IN_TARGETS,
      DISCARD
   } parse_phase_type;

   logic clock = 1'b0;
   logic reset;

   arsp_req_if req_chan ();
   arsp_rsp_if rsp_chan ();

   action_record_stream_parser uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Decoder state mirrored by the testbench
   parse_phase_type phase;
   logic [3:0]   field_pos;
   logic [7:0]   rec_type;      // whole type byte, so 9 is not mistaken for start
   logic [7:0]   rec_id;
   logic [7:0]   pin_bytes [5];
   logic [31:0]  millis;
   logic [15:0]  micros;
   logic [7:0]   targets_due;
   logic [8:0]   top_id;        // bit 8 set while no id has been seen
   logic [2:0]   first_error;

   result_type   decoded_q [$];    // results still owed by the block
   stim_row_type plan_q [$];       // items waiting to be sent
   logic [7:0]   record_bytes [$];

   int  src_idle_pct = 28;
   int  snk_idle_pct = 78;
   int  live_items;
   int  mismatches = 0;
   int  quiet_cycles = 0;
   bit  huge_record_done = 0;

   // Number of pin bytes ahead of the duration for a record type
   function automatic int pin_byte_len(input logic [7:0] t);
      if (t == REC_PIN_READ || t == REC_PIN_WRITE) return 5;
      if (t == REC_PIN_TRIGGER) return 4;
      return 0;
   endfunction

   function automatic result_type end_status(input logic [2:0] st, input logic [8:0] cnt);
      result_type r;
      r        = '0;
      r.kind   = KIND_END;
      r.count  = cnt;
      r.status = st;
      return r;
   endfunction

   function automatic result_type record_out(input logic [2:0] t, input logic [7:0] id,
                                             input logic [31:0] ticks,
                                             input logic [8:0] cnt);
      result_type r;
      r                = '0;
      r.kind           = KIND_RECORD;
      r.action_type    = t;
      r.action_id      = id;
      r.interval_ticks = ticks;
      r.count          = cnt;
      return r;
   endfunction

   function automatic result_type target_out(input logic [2:0] t, input logic [7:0] id,
                                             input logic [7:0] tid);
      result_type r;
      r             = '0;
      r.kind        = KIND_TARGET;
      r.action_type = t;
      r.action_id   = id;
      r.target_id   = tid;
      return r;
   endfunction

   // Return the decoder to the start of a payload
   task automatic clear_parse();
      phase       = AWAIT_TYPE;
      field_pos   = '0;
      rec_type    = '0;
      rec_id      = '0;
      pin_bytes   = '{default: '0};
      millis      = '0;
      micros      = '0;
      targets_due = '0;
      top_id      = 9'h100;
      first_error = ST_OK;
   endtask

   // Advance the decoder by one accepted item; flag and fill the result it causes
   task automatic decode_item(input logic rtype, input logic [7:0] b,
                              output bit made, output result_type res);
      int               np;
      int               fixed;
      logic [2:0]       st;
      longint unsigned  wide;
      res  = '0;
      made = 1'b0;
      if (rtype == REQ_END) begin
         // Report where the payload stopped, or the first error
         case (phase)
            DISCARD:    st = first_error;
            AWAIT_ID:   st = ST_SHORT_HEADER;
            IN_FIELDS:  st = ST_SHORT_FIELDS;
            IN_TARGETS: st = ST_SHORT_TARGETS;
            default:    st = ST_OK;
         endcase
         res.kind   = KIND_END;
         res.status = st;
         if (st == ST_OK && !top_id[8]) res.count = {1'b0, top_id[7:0]} + 9'd1;
         made = 1'b1;
         clear_parse();
      end else begin
         case (phase)
            AWAIT_TYPE: begin
               rec_type = b;
               phase    = AWAIT_ID;
            end
            AWAIT_ID: begin
               rec_id = b;
               // The id counts toward the action count even for a bad type
               if (top_id[8] || b > top_id[7:0]) top_id = {1'b0, b};
               if (rec_type < REC_START || rec_type > REC_PIN_TRIGGER) begin
                  first_error = ST_BAD_TYPE;
                  phase       = DISCARD;
               end else begin
                  field_pos = '0;
                  pin_bytes = '{default: '0};
                  millis    = '0;
                  micros    = '0;
                  phase     = IN_FIELDS;
               end
            end
            IN_FIELDS: begin
               np    = pin_byte_len(rec_type);
               fixed = (rec_type == REC_START) ? 0 : np + 6;
               if (field_pos < fixed) begin
                  // Collect pin bytes, then big-endian ms and us
                  if (field_pos < np) pin_bytes[field_pos[2:0]] = b;
                  else if (field_pos - np < 4) millis = {millis[23:0], b};
                  else micros = {micros[7:0], b};
                  field_pos = field_pos + 4'd1;
               end else begin
                  // Count byte: the record goes out now
                  res.kind        = KIND_RECORD;
                  res.action_type = rec_type[2:0];
                  res.action_id   = rec_id;
                  if (np != 0) begin
                     res.port          = pin_bytes[0];
                     res.pin           = pin_bytes[1];
                     res.initial_level = pin_bytes[2];
                     res.target_level  = pin_bytes[3];
                     res.final_level   = (rec_type == REC_PIN_TRIGGER) ? 8'h00 : pin_bytes[4];
                  end
                  if (rec_type != REC_START) begin
                     wide = 64'(millis) * 64'(TICKS_PER_MS)
                          + (64'(micros) + 64'(TICK_US / 2)) / 64'(TICK_US);
                     res.interval_ticks = (wide > 64'(TICKS_MAX)) ? TICKS_MAX : wide[31:0];
                  end
                  res.count   = {1'b0, b};
                  targets_due = b;
                  phase       = (b != 0) ? IN_TARGETS : AWAIT_TYPE;
                  made        = 1'b1;
               end
            end
            IN_TARGETS: begin
               res.kind        = KIND_TARGET;
               res.action_type = rec_type[2:0];
               res.action_id   = rec_id;
               res.target_id   = b;
               targets_due     = targets_due - 8'd1;
               if (targets_due == 0) phase = AWAIT_TYPE;
               made = 1'b1;
            end
            default: ;   // drop bytes after an error until the end marker
         endcase
      end
   endtask

   task automatic plan(input logic rtype, input logic [7:0] data,
                       input bit pinned = 1'b0, input result_type want = '0);
      stim_row_type r;
      r.rtype  = rtype;
      r.data   = data;
      r.pinned = pinned;
      r.want   = want;
      plan_q.push_back(r);
   endtask

   // Pick a byte with the extremes well represented
   function automatic logic [7:0] pick_byte();
      case ($urandom_range(7))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   // Build one complete record of random type and content in record_bytes
   task automatic compose_record();
      logic [7:0]  t;
      logic [31:0] ms;
      logic [15:0] us;
      int          n;
      int          r;
      record_bytes.delete();
      t = 8'($urandom_range(REC_PIN_TRIGGER, REC_START));
      record_bytes.push_back(t);
      record_bytes.push_back($urandom_range(1) ? 8'($urandom_range(15)) : pick_byte());
      repeat (pin_byte_len(t)) record_bytes.push_back(pick_byte());
      if (t != REC_START) begin
         case ($urandom_range(4))
            0:       ms = '0;
            1:       ms = '1;
            2:       ms = $urandom_range(5000);
            3:       ms = 32'd42949672 + $urandom_range(1);   // edge of saturation
            default: ms = $urandom;
         endcase
         case ($urandom_range(3))
            0:       us = '0;
            1:       us = '1;
            2:       us = 16'($urandom_range(40));            // rounding edges
            default: us = 16'($urandom);
         endcase
         record_bytes.push_back(ms[31:24]);
         record_bytes.push_back(ms[23:16]);
         record_bytes.push_back(ms[15:8]);
         record_bytes.push_back(ms[7:0]);
         record_bytes.push_back(us[15:8]);
         record_bytes.push_back(us[7:0]);
      end
      // Keep target lists short; allow one full-size list per run
      r = $urandom_range(99);
      if (r < 88) n = $urandom_range(3);
      else if (r < 99 || huge_record_done) n = $urandom_range(16, 4);
      else begin
         n = 255;
         huge_record_done = 1'b1;
      end
      record_bytes.push_back(8'(n));
      repeat (n) record_bytes.push_back(pick_byte());
   endtask

   task automatic plan_record_bytes(input int upto);
      for (int i = 0; i < upto; i++) plan(REQ_BYTE, record_bytes[i]);
   endtask

   // Queue one random payload, mostly well formed, ended by the end marker
   task automatic build_payload();
      int shape;
      shape = $urandom_range(99);
      if (shape < 68) begin
         repeat ($urandom_range(4, 1)) begin
            compose_record();
            plan_record_bytes(record_bytes.size());
         end
      end else if (shape < 80) begin
         // Whole records, then one cut short anywhere after its type byte
         repeat ($urandom_range(2)) begin
            compose_record();
            plan_record_bytes(record_bytes.size());
         end
         compose_record();
         plan_record_bytes($urandom_range(record_bytes.size() - 1, 1));
      end else if (shape < 90) begin
         // Unknown type, possibly after good records, then bytes to ignore
         repeat ($urandom_range(1)) begin
            compose_record();
            plan_record_bytes(record_bytes.size());
         end
         plan(REQ_BYTE, $urandom_range(1) ? 8'h00 : 8'($urandom_range(255, 6)));
         plan(REQ_BYTE, pick_byte());
         repeat ($urandom_range(6)) plan(REQ_BYTE, 8'($urandom));
      end else if (shape >= 95) begin
         repeat ($urandom_range(10, 1)) plan(REQ_BYTE, 8'($urandom));
      end
      // shapes 90..94 leave the payload empty
      plan(REQ_END, 8'($urandom));
   endtask

   // Offer one item at the falling edge and hold it until it is accepted
   task automatic send_row(input stim_row_type r);
      bit         made;
      result_type guess;
      if (phase != DISCARD) live_items++;
      decode_item(r.rtype, r.data, made, guess);
      if (r.pinned) decoded_q.push_back(r.want);
      else if (made) decoded_q.push_back(guess);
      while ($urandom_range(99) < src_idle_pct) begin
         req_chan.valid     <= 1'b0;
         req_chan.req_type  <= 1'($urandom);
         req_chan.data_byte <= 8'($urandom);
         @(negedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.req_type  <= r.rtype;
      req_chan.data_byte <= r.data;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] seen);
      if (want !== seen) begin
         $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, seen);
         mismatches++;
      end
   endtask

   // Receiver: randomly stall, changing ready only at the falling edge
   always @(negedge clock) rsp_chan.ready <= ($urandom_range(99) >= snk_idle_pct);

   // Compare every accepted result with the oldest one owed
   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got = {rsp_chan.kind, rsp_chan.action_type, rsp_chan.action_id, rsp_chan.port,
                rsp_chan.pin, rsp_chan.initial_level, rsp_chan.target_level,
                rsp_chan.final_level, rsp_chan.interval_ticks, rsp_chan.count,
                rsp_chan.target_id, rsp_chan.status};
         if (decoded_q.size() == 0) begin
            $display("%0t ns: unexpected result, expected none, got kind %0d type %0d id %0h",
                     $time, got.kind, got.action_type, got.action_id);
            mismatches++;
         end else begin
            want = decoded_q.pop_front();
            check_field("kind",           32'(want.kind),          32'(got.kind));
            check_field("action_type",    32'(want.action_type),   32'(got.action_type));
            check_field("action_id",      32'(want.action_id),     32'(got.action_id));
            check_field("port",           32'(want.port),          32'(got.port));
            check_field("pin",            32'(want.pin),           32'(got.pin));
            check_field("initial_level",  32'(want.initial_level), 32'(got.initial_level));
            check_field("target_level",   32'(want.target_level),  32'(got.target_level));
            check_field("final_level",    32'(want.final_level),   32'(got.final_level));
            check_field("interval_ticks", want.interval_ticks,     got.interval_ticks);
            check_field("count",          32'(want.count),         32'(got.count));
            check_field("target_id",      32'(want.target_id),     32'(got.target_id));
            check_field("status",         32'(want.status),        32'(got.status));
         end
      end
   end

   // Watchdog: end the run if neither channel moves an item for too long
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t ns: no handshake for %0d cycles, %0d results owed",
                  $time, quiet_cycles, decoded_q.size());
         $display("FAIL action_record_stream_parser");
         $finish;
      end
   end

   initial begin
      // Hold every input at a known value from time zero
      reset              = 1'b1;
      req_chan.valid     = 1'b0;
      req_chan.req_type  = REQ_BYTE;
      req_chan.data_byte = 8'h00;
      rsp_chan.ready     = 1'b0;
      clear_parse();

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed table: extremes, errors and truncation points
      // empty payload right after reset: no actions
      plan(REQ_END,  8'h00, 1, end_status(ST_OK, 9'd0));
      // start record, id 7, no targets
      plan(REQ_BYTE, 8'(REC_START));
      plan(REQ_BYTE, 8'h07);
      plan(REQ_BYTE, 8'h00, 1, record_out(REC_START, 8'h07, 32'd0, 9'd0));
      // delay record with all-ones duration: saturates; top id makes count 256
      plan(REQ_BYTE, 8'(REC_DELAY));
      plan(REQ_BYTE, 8'hFF);
      plan(REQ_BYTE, 8'hFF);
      plan(REQ_BYTE, 8'hFF);
      plan(REQ_BYTE, 8'hFF);
      plan(REQ_BYTE, 8'hFF);
      plan(REQ_BYTE, 8'hFF);
      plan(REQ_BYTE, 8'hFF);
      plan(REQ_BYTE, 8'h02, 1, record_out(REC_DELAY, 8'hFF, TICKS_MAX, 9'd2));
      plan(REQ_BYTE, 8'h00, 1, target_out(REC_DELAY, 8'hFF, 8'h00));
      plan(REQ_BYTE, 8'hFF, 1, target_out(REC_DELAY, 8'hFF, 8'hFF));
      plan(REQ_END,  8'hFF, 1, end_status(ST_OK, 9'd256));
      // unknown type zero; the trailing byte is dropped
      plan(REQ_BYTE, 8'h00);
      plan(REQ_BYTE, 8'h09);
      plan(REQ_BYTE, 8'hAA);
      plan(REQ_END,  8'h00, 1, end_status(ST_BAD_TYPE, 9'd0));
      // type byte only
      plan(REQ_BYTE, 8'(REC_PIN_READ));
      plan(REQ_END,  8'h00, 1, end_status(ST_SHORT_HEADER, 9'd0));
      // stop inside the pin bytes
      plan(REQ_BYTE, 8'(REC_PIN_WRITE));
      plan(REQ_BYTE, 8'h01);
      plan(REQ_BYTE, 8'h7F);
      plan(REQ_END,  8'h00, 1, end_status(ST_SHORT_FIELDS, 9'd0));
      // stop inside the target list
      plan(REQ_BYTE, 8'(REC_START));
      plan(REQ_BYTE, 8'h00);
      plan(REQ_BYTE, 8'h03, 1, record_out(REC_START, 8'h00, 32'd0, 9'd3));
      plan(REQ_BYTE, 8'h11, 1, target_out(REC_START, 8'h00, 8'h11));
      plan(REQ_END,  8'h00, 1, end_status(ST_SHORT_TARGETS, 9'd0));

      while (plan_q.size() != 0) send_row(plan_q.pop_front());

      // Random payloads; move through the three stall mixes as items go out
      live_items = 0;
      while (live_items < RANDOM_ITEMS) begin
         build_payload();
         while (plan_q.size() != 0) begin
            if (live_items < RANDOM_ITEMS / 3) begin
               src_idle_pct = 28;
               snk_idle_pct = 78;
            end else if (live_items < 2 * RANDOM_ITEMS / 3) begin
               src_idle_pct = 78;
               snk_idle_pct = 28;
            end else begin
               src_idle_pct = 0;
               snk_idle_pct = 0;
            end
            send_row(plan_q.pop_front());
         end
      end
      req_chan.valid <= 1'b0;

      // Drain: wait for every owed result, then linger to catch extras
      while (decoded_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0)
         $display("PASS action_record_stream_parser");
      else
         $display("FAIL action_record_stream_parser");
      $finish;
   end

endmodule

[action_record_stream_parser.f]
src/arsp_pkg.sv
src/arsp_req_if.sv
src/arsp_rsp_if.sv
src/arsp_front.sv
src/arsp_queue.sv
src/arsp_back.sv
src/action_record_stream_parser.sv
verif/tb.sv
